[design/bse_pkg.sv]
// Shared types and state codes for the bubble sort engine.
// Used by bubble_sort_engine and bse_cmpx; depends on nothing else.
`timescale 1ns / 1ps

package bse_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
    } t_out_req;

    // Result of one compare-and-swap step.
    typedef struct packed {
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic                     swap;
    } t_cmpx;

    localparam logic [2:0] S_FILL  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_TAIL  = 3'd3;
    localparam logic [2:0] S_EREAD = 3'd4;
    localparam logic [2:0] S_ELOAD = 3'd5;

endpackage

[design/bubble_sort_engine.sv]
// Top level of the bubble sort engine: sequencer, element RAM and output register.
// Depends on bse_pkg, bse_ram and bse_cmpx.
//
// Usage: values enter on the input channel (i_in_valid / o_in_stall, payload
// i_in_req) one per cycle while the engine is collecting. Up to MAX_ITEMS values
// are stored; extra values are dropped. A request with is_last set closes the
// set and the engine stalls its input while it sorts and emits.
// Sorting runs passes over the RAM with the running maximum held in a register:
// each pass does one compare per cycle (the RAM read port being the pacing
// resource), and passes repeat until one makes no swap.
// Results leave on the output channel (o_out_valid / i_out_stall, payload
// o_out_req) in ascending order, last_out on the largest.
// A stalled result simply holds in the output register and emission waits.
// After the last result is loaded the engine returns to collecting while that
// result may still be waiting. Reset clears the count and the control state;
// the RAM contents are not cleared and are never used before being written.
`timescale 1ns / 1ps

module bubble_sort_engine
    import bse_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_req  i_in_req,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_out_req o_out_req,
    input  logic     i_out_stall
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = AW + 1;

    logic [2:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_num, n_num;
    logic [AW-1:0]           r_k, n_k;
    logic                    r_swapped, n_swapped;
    logic signed [DATA_W-1:0] r_hold, n_hold;
    logic                    r_out_valid, n_out_valid;
    t_out_req                r_out_req, n_out_req;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [DATA_W-1:0]       ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [DATA_W-1:0]       ram_rdata;

    logic                    in_acc;
    logic                    has_room;
    logic [CW-1:0]           k_ext;
    logic [CW-1:0]           k_plus1;
    logic [CW-1:0]           k_plus2;
    logic [CW-1:0]           fill_num;
    logic                    emit_last;
    logic                    out_free;
    t_cmpx                   cs;

    bse_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_ITEMS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    bse_cmpx u_cmpx (
        .i_a  (r_hold),
        .i_b  ($signed(ram_rdata)),
        .o_res(cs)
    );

    assign o_in_stall  = (r_state != S_FILL);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign has_room    = r_count < CW'(MAX_ITEMS);
    assign k_ext       = {1'b0, r_k};
    assign k_plus1     = k_ext + CW'(1);
    assign k_plus2     = k_ext + CW'(2);
    assign fill_num    = has_room ? r_count + CW'(1) : r_count;
    assign emit_last   = (k_plus1 == r_num);
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_num       = r_num;
        n_k         = r_k;
        n_swapped   = r_swapped;
        n_hold      = r_hold;
        n_out_req   = r_out_req;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_k;
        ram_wdata   = cs.lo;
        ram_raddr   = r_k;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_FILL: begin
                ram_raddr = '0;
                if (in_acc) begin
                    if (has_room) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[AW-1:0];
                        ram_wdata = i_in_req.value;
                        n_count   = r_count + CW'(1);
                    end
                    if (i_in_req.is_last) begin
                        n_num     = fill_num;
                        n_swapped = 1'b0;
                        n_k       = '0;
                        if (fill_num >= CW'(2)) begin
                            n_state = S_FIRST;
                        end else begin
                            n_state = S_EREAD;
                        end
                    end
                end
            end
            S_FIRST: begin
                // Entry 0 is on the read port; start fetching entry 1.
                n_hold    = $signed(ram_rdata);
                ram_raddr = AW'(1);
                n_k       = '0;
                n_state   = S_CMP;
            end
            S_CMP: begin
                // The smaller value settles at k, the larger keeps bubbling up.
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = cs.lo;
                n_hold    = cs.hi;
                n_swapped = r_swapped | cs.swap;
                ram_raddr = k_plus2[AW-1:0];
                if (k_plus2 == r_num) begin
                    n_state = S_TAIL;
                end else begin
                    n_k = k_plus1[AW-1:0];
                end
            end
            S_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = k_plus1[AW-1:0];
                ram_wdata = r_hold;
                ram_raddr = '0;
                n_k       = '0;
                if (r_swapped) begin
                    n_swapped = 1'b0;
                    n_state   = S_FIRST;
                end else begin
                    n_state = S_EREAD;
                end
            end
            S_EREAD: begin
                n_state = S_ELOAD;
            end
            S_ELOAD: begin
                // The read address holds, so the RAM data stays put while stalled.
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_req.sorted_value = $signed(ram_rdata);
                    n_out_req.last_out     = emit_last;
                    if (emit_last) begin
                        n_count = '0;
                        n_state = S_FILL;
                    end else begin
                        n_k     = k_plus1[AW-1:0];
                        n_state = S_EREAD;
                    end
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_count     <= '0;
            r_swapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_swapped   <= n_swapped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num     <= n_num;
        r_k       <= n_k;
        r_hold    <= n_hold;
        r_out_req <= n_out_req;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("element count exceeds capacity");

    a_fill_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && ram_we) |-> has_room)
        else $error("store write while full");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (k_plus1 < r_num))
        else $error("compare index beyond stored set");

    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ELOAD && out_free && emit_last)
            |=> (r_state == S_FILL && r_count == '0 && o_out_req.last_out))
        else $error("final result did not return engine to collecting");

endmodule

[design/bse_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/bse_cmpx.sv]
// Signed compare-and-swap unit for one adjacent pair.
// Depends on bse_pkg for the data width and the result struct.
`timescale 1ns / 1ps

module bse_cmpx
    import bse_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output t_cmpx                    o_res
);

    logic gt;

    // Equal values are left in place, which keeps the sort stable.
    assign gt           = i_a > i_b;
    assign o_res.swap   = gt;
    assign o_res.lo     = gt ? i_b : i_a;
    assign o_res.hi     = gt ? i_a : i_b;

endmodule
